FILE: rtl/uvs_pkg.sv
// Shared constants, types and tables of the UV-sphere vertex and index generator.
`timescale 1ns / 1ps
`default_nettype none
package uvs_pkg;

    // Ring limit and derived widths
    localparam int MAX_RINGS    = 64;
    localparam int V_W          = $clog2(MAX_RINGS + 1);
    localparam int RING_W       = 7;
    localparam int SEG_W        = 8;
    localparam int PHASE_W      = 16;
    localparam int NUM_W        = SEG_W + 15;
    localparam int RECIP_SH     = NUM_W + V_W;
    localparam int RECIP_W      = RECIP_SH - 1;
    localparam int IDX_W        = 14;
    localparam int POS_W        = 17;
    localparam int RAD_W        = 16;
    localparam int ROT_W        = 18;
    localparam int TRIG_W       = 16;
    localparam int MAG_W        = 15;
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_W       = 14;

    // CORDIC start value, quarter, half and three-quarter turn phases, trig limit
    localparam logic signed [ROT_W-1:0] CORDIC_GAIN_INIT = ROT_W'(19898);
    localparam logic [PHASE_W-1:0] QUARTER_TURN = PHASE_W'(16384);
    localparam logic [PHASE_W-1:0] HALF_TURN    = PHASE_W'(32768);
    localparam logic [PHASE_W-1:0] THREE_QUARTER_TURN = PHASE_W'(49152);
    localparam logic signed [TRIG_W-1:0] TRIG_LIMIT = TRIG_W'(32767);

    // Arctangent of 2^-k in phase units (full turn is 65536)
    localparam logic [ATAN_W-1:0] ATAN_TAB [0:CORDIC_STEPS-1] = '{
        14'd8192, 14'd4836, 14'd2555, 14'd1297, 14'd651, 14'd326, 14'd163, 14'd81,
        14'd41, 14'd20, 14'd10, 14'd5, 14'd3, 14'd1, 14'd1, 14'd0
    };

    // Triangle index slots
    localparam int IDX_ONE_A = 0;
    localparam int IDX_ONE_B = 1;
    localparam int IDX_ONE_C = 2;
    localparam int IDX_TWO_A = 3;
    localparam int IDX_TWO_B = 4;
    localparam int IDX_TWO_C = 5;

    // Configuration register addresses (bit 2 of paddr)
    localparam logic ADDR_RADIUS     = 1'b0;
    localparam logic ADDR_RING_COUNT = 1'b1;

    typedef struct packed {
        logic signed [ROT_W-1:0] x;
        logic signed [ROT_W-1:0] y;
        logic signed [ROT_W-1:0] z;
    } rot_t;

    typedef struct packed {
        logic                 err;
        logic                 quad;
        logic                 flip_lat;
        logic                 flip_lon;
        logic [5:0][IDX_W-1:0] idx;
    } side_t;

    typedef struct packed {
        rot_t  lat;
        rot_t  lon;
        side_t side;
    } cell_t;

endpackage
`default_nettype wire

FILE: rtl/uv_sphere_vertex_index_generator.sv
// Top level: register port, front stages, CORDIC cell chain and back stages.
//
// Usage: each item on the s_axis channel is one grid point (ring, segment) of
// a latitude-longitude sphere. For each item one result leaves on m_axis: the
// vertex position (x, y, z in signed Q8.8) and the six indices of the two
// triangles of the quad at that point, plus flags in tuser.
// The APB port holds the radius (address 0) and the ring count (address 4).
// Change them only while no item is in flight.
// Between accept and result lie three front stages (capture, divide by ring
// count, fold), sixteen CORDIC cells and two back stages (products, radius
// scaling and output register). Throughput is one item per cycle while
// m_axis_tready is high; every stage holds its own valid bit, so the
// pipeline keeps accepting until it is full.
// When the receiver stalls, the result holds on m_axis and stages fill behind
// it; s_axis_tready falls once every stage holds an item.
// Reset empties the pipeline and sets radius 5.0 and ring count 15.
`timescale 1ns / 1ps
`default_nettype none
module uv_sphere_vertex_index_generator
    import uvs_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output      logic         s_axis_tready,
    input  wire logic [15:0]  s_axis_tdata,   // ring[6:0], segment[14:7]
    output      logic         m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // pos_x, pos_y, pos_z, tri_one_a/b/c, tri_two_a/b/c from bit 0 up
    output      logic [135:0] m_axis_tdata,
    output      logic [1:0]   m_axis_tuser,   // quad_valid[0], range_error[1]
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output      logic [31:0]  prdata,
    output      logic         pready
);

    logic [RAD_W-1:0]      radius_reg;
    logic [6:0]            ring_count_reg;
    logic                  wr_en;
    logic                  f_valid;
    logic                  f_ready;
    cell_t                 f_data;
    logic                  c_valid [0:CORDIC_STEPS];
    logic                  c_ready [0:CORDIC_STEPS];
    cell_t                 c_data  [0:CORDIC_STEPS];
    logic [POS_W-1:0]      pos_x;
    logic [POS_W-1:0]      pos_y;
    logic [POS_W-1:0]      pos_z;
    logic [5:0][IDX_W-1:0] idx;
    logic                  quad_valid;
    logic                  range_error;

    // Configuration registers
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg     <= RAD_W'(1280);
            ring_count_reg <= 7'd15;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                ADDR_RADIUS:     radius_reg     <= pwdata[RAD_W-1:0];
                ADDR_RING_COUNT: ring_count_reg <= pwdata[6:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            ADDR_RADIUS:     prdata = 32'(radius_reg);
            ADDR_RING_COUNT: prdata = 32'(ring_count_reg);
            default:         prdata = '0;
        endcase
    end

    uvs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .ring       (s_axis_tdata[6:0]),
        .segment    (s_axis_tdata[14:7]),
        .ring_count (ring_count_reg),
        .out_valid  (f_valid),
        .out_ready  (f_ready),
        .out_data   (f_data)
    );

    assign c_valid[0] = f_valid;
    assign c_data[0]  = f_data;
    assign f_ready    = c_ready[0];

    // Chain of CORDIC cells, one iteration each
    for (genvar g = 0; g < CORDIC_STEPS; g++)
    begin : g_cell
        uvs_cordic_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (c_valid[g]),
            .in_ready  (c_ready[g]),
            .in_data   (c_data[g]),
            .shift     (4'(g)),
            .atan      (ATAN_TAB[g]),
            .out_valid (c_valid[g+1]),
            .out_ready (c_ready[g+1]),
            .out_data  (c_data[g+1])
        );
    end

    uvs_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (c_valid[CORDIC_STEPS]),
        .in_ready    (c_ready[CORDIC_STEPS]),
        .in_data     (c_data[CORDIC_STEPS]),
        .radius      (radius_reg),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .idx         (idx),
        .quad_valid  (quad_valid),
        .range_error (range_error)
    );

    // Pack the result item
    assign m_axis_tdata = {1'b0,
                           idx[IDX_TWO_C], idx[IDX_TWO_B], idx[IDX_TWO_A],
                           idx[IDX_ONE_C], idx[IDX_ONE_B], idx[IDX_ONE_A],
                           pos_z, pos_y, pos_x};
    assign m_axis_tuser = {range_error, quad_valid};

endmodule
`default_nettype wire

FILE: rtl/uvs_front.sv
// Front stages: phase division by the ring count, quadrant fold and triangle indices.
`timescale 1ns / 1ps
`default_nettype none
module uvs_front
    import uvs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output      logic              in_ready,
    input  wire logic [RING_W-1:0] ring,
    input  wire logic [SEG_W-1:0]  segment,
    input  wire logic [6:0]        ring_count,
    output      logic              out_valid,
    input  wire logic              out_ready,
    output      cell_t             out_data
);

    logic [V_W-1:0]          v;
    logic [RECIP_W-1:0]      recip_tab [0:MAX_RINGS];
    logic                    a_valid_reg;
    logic [RING_W-1:0]       a_ring_reg;
    logic [SEG_W-1:0]        a_seg_reg;
    logic                    a_ready;
    logic                    b_valid_reg;
    logic [RING_W-1:0]       b_ring_reg;
    logic [SEG_W-1:0]        b_seg_reg;
    logic                    b_err_reg;
    logic [PHASE_W-1:0]      b_lat_reg;
    logic [PHASE_W-1:0]      b_lon_reg;
    logic                    b_ready;
    logic                    b_err_next;
    logic [NUM_W-1:0]        num_lat;
    logic [NUM_W-1:0]        num_lon;
    logic [RECIP_W-1:0]      recip;
    logic [NUM_W+RECIP_W-1:0] prod_lat;
    logic [NUM_W+RECIP_W-1:0] prod_lon;
    logic                    c_valid_reg;
    logic                    c_ready;
    cell_t                   c_data_reg;
    cell_t                   c_data_next;
    logic [PHASE_W-1:0]      lat_ph;
    logic [V_W:0]            stride;
    logic [SEG_W:0]          seg_inc;
    logic [SEG_W:0]          nseg;
    logic [IDX_W-1:0]        row_lo;
    logic [IDX_W-1:0]        row_hi;
    logic                    quad;

    // Fold a phase into the right half plane and start a rotator
    function automatic rot_t fold_start(input logic [PHASE_W-1:0] ph, output logic flip);
        logic [PHASE_W-1:0] p;
        rot_t r;
        flip = (ph >= QUARTER_TURN) && (ph < THREE_QUARTER_TURN);
        p = flip ? ph + HALF_TURN : ph;
        r.x = CORDIC_GAIN_INIT;
        r.y = '0;
        r.z = ROT_W'(signed'(p));
        return r;
    endfunction

    // Clamp the ring count register
    always_comb
    begin
        if (ring_count < 7'd3)
            v = V_W'(3);
        else if (ring_count > 7'(MAX_RINGS))
            v = V_W'(MAX_RINGS);
        else
            v = V_W'(ring_count);
    end

    // Reciprocal table: ceil(2^RECIP_SH / v), exact floor division for every numerator
    for (genvar g = 0; g <= MAX_RINGS; g++)
    begin : g_recip
        if (g < 3)
        begin : g_none
            assign recip_tab[g] = '0;
        end
        else
        begin : g_val
            localparam longint unsigned RV = ((64'd1 << RECIP_SH) + g - 1) / g;
            assign recip_tab[g] = RECIP_W'(RV);
        end
    end

    // Stage A: capture the grid point
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (a_ready)
            a_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_ring_reg <= ring;
            a_seg_reg  <= segment;
        end
    end

    // Stage B: rounded division into phases, range check
    always_comb
    begin
        b_err_next = (a_ring_reg > RING_W'(v)) || (a_seg_reg > SEG_W'({v, 1'b0}));
        num_lat    = NUM_W'({a_ring_reg, 15'd0}) + NUM_W'(v >> 1);
        num_lon    = NUM_W'({a_seg_reg, 15'd0}) + NUM_W'(v >> 1);
        recip      = recip_tab[v];
        prod_lat   = (NUM_W+RECIP_W)'(num_lat) * (NUM_W+RECIP_W)'(recip);
        prod_lon   = (NUM_W+RECIP_W)'(num_lon) * (NUM_W+RECIP_W)'(recip);
    end

    assign b_ready = !b_valid_reg || c_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (b_ready)
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && a_valid_reg)
        begin
            b_ring_reg <= a_ring_reg;
            b_seg_reg  <= a_seg_reg;
            b_err_reg  <= b_err_next;
            b_lat_reg  <= prod_lat[RECIP_SH+PHASE_W-1:RECIP_SH];
            b_lon_reg  <= prod_lon[RECIP_SH+PHASE_W-1:RECIP_SH];
        end
    end

    // Stage C: fold phases, build triangle indices
    always_comb
    begin
        lat_ph  = b_lat_reg - QUARTER_TURN;
        stride  = {v, 1'b1};
        seg_inc = {1'b0, b_seg_reg} + 1'b1;
        nseg    = (seg_inc == (SEG_W+1)'(stride)) ? '0 : seg_inc;
        row_lo  = IDX_W'(b_ring_reg) * IDX_W'(stride);
        row_hi  = (IDX_W'(b_ring_reg) + IDX_W'(1)) * IDX_W'(stride);
        quad    = !b_err_reg && (b_ring_reg < RING_W'(v));

        c_data_next.lat = fold_start(lat_ph, c_data_next.side.flip_lat);
        c_data_next.lon = fold_start(b_lon_reg, c_data_next.side.flip_lon);
        c_data_next.side.err  = b_err_reg;
        c_data_next.side.quad = quad;
        c_data_next.side.idx[IDX_ONE_A] = row_lo + IDX_W'(nseg);
        c_data_next.side.idx[IDX_ONE_B] = row_hi + IDX_W'(b_seg_reg);
        c_data_next.side.idx[IDX_ONE_C] = row_lo + IDX_W'(b_seg_reg);
        c_data_next.side.idx[IDX_TWO_A] = row_hi + IDX_W'(nseg);
        c_data_next.side.idx[IDX_TWO_B] = row_hi + IDX_W'(b_seg_reg);
        c_data_next.side.idx[IDX_TWO_C] = row_lo + IDX_W'(nseg);
        if (!quad)
            c_data_next.side.idx = '0;
    end

    assign c_ready = !c_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_valid_reg <= 1'b0;
        else if (c_ready)
            c_valid_reg <= b_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (c_ready && b_valid_reg)
            c_data_reg <= c_data_next;
    end

    assign out_valid = c_valid_reg;
    assign out_data  = c_data_reg;

endmodule
`default_nettype wire

FILE: rtl/uvs_cordic_cell.sv
// One CORDIC iteration for both the latitude and longitude rotators.
`timescale 1ns / 1ps
`default_nettype none
module uvs_cordic_cell
    import uvs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output      logic              in_ready,
    input  wire cell_t             in_data,
    input  wire logic [3:0]        shift,
    input  wire logic [ATAN_W-1:0] atan,
    output      logic              out_valid,
    input  wire logic              out_ready,
    output      cell_t             out_data
);

    logic  valid_reg;
    cell_t data_reg;
    cell_t data_next;

    // Rotate toward zero residual phase
    function automatic rot_t rotate(input rot_t r, input logic [3:0] s,
                                    input logic [ATAN_W-1:0] a);
        rot_t o;
        logic signed [ROT_W-1:0] xs;
        logic signed [ROT_W-1:0] ys;
        logic signed [ROT_W-1:0] at;
        xs = r.x >>> s;
        ys = r.y >>> s;
        at = signed'(ROT_W'(a));
        if (!r.z[ROT_W-1])
        begin
            o.x = r.x - ys;
            o.y = r.y + xs;
            o.z = r.z - at;
        end
        else
        begin
            o.x = r.x + ys;
            o.y = r.y - xs;
            o.z = r.z + at;
        end
        return o;
    endfunction

    always_comb
    begin
        data_next      = in_data;
        data_next.lat  = rotate(in_data.lat, shift, atan);
        data_next.lon  = rotate(in_data.lon, shift, atan);
    end

    // Advance when empty or when the neighbor takes the held item
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
`default_nettype wire

FILE: rtl/uvs_back.sv
// Back stages: unfold and clamp sine and cosine, scale by the radius, output register.
`timescale 1ns / 1ps
`default_nettype none
module uvs_back
    import uvs_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output      logic                     in_ready,
    input  wire cell_t                    in_data,
    input  wire logic [RAD_W-1:0]         radius,
    output      logic                     out_valid,
    input  wire logic                     out_ready,
    output      logic [POS_W-1:0]         pos_x,
    output      logic [POS_W-1:0]         pos_y,
    output      logic [POS_W-1:0]         pos_z,
    output      logic [5:0][IDX_W-1:0]    idx,
    output      logic                     quad_valid,
    output      logic                     range_error
);

    localparam int PM_W = 2 * MAG_W;
    localparam int PY_W = RAD_W + MAG_W;
    localparam int PX_W = RAD_W + PM_W;

    logic signed [TRIG_W-1:0] slat;
    logic signed [TRIG_W-1:0] clat;
    logic signed [TRIG_W-1:0] slon;
    logic signed [TRIG_W-1:0] clon;
    logic                     p1_valid_reg;
    logic                     p1_ready;
    logic [PM_W-1:0]          p1_mx_reg;
    logic [PM_W-1:0]          p1_mz_reg;
    logic [PY_W-1:0]          p1_my_reg;
    logic                     p1_nx_reg;
    logic                     p1_ny_reg;
    logic                     p1_nz_reg;
    side_t                    p1_side_reg;
    logic                     p2_valid_reg;
    logic                     p2_ready;
    logic [PX_W-1:0]          sx;
    logic [PX_W-1:0]          sz;
    logic [PY_W-1:0]          sy;
    logic [POS_W-1:0]         px_next;
    logic [POS_W-1:0]         py_next;
    logic [POS_W-1:0]         pz_next;
    logic [POS_W-1:0]         px_reg;
    logic [POS_W-1:0]         py_reg;
    logic [POS_W-1:0]         pz_reg;
    logic [5:0][IDX_W-1:0]    idx_reg;
    logic                     quad_reg;
    logic                     err_reg;

    // Undo the half-turn fold and clamp to Q1.15
    function automatic logic signed [TRIG_W-1:0] finish(input logic signed [ROT_W-1:0] v,
                                                        input logic flip);
        logic signed [ROT_W-1:0] t;
        t = flip ? -v : v;
        if (t > ROT_W'(TRIG_LIMIT))
            return TRIG_LIMIT;
        else if (t < -ROT_W'(TRIG_LIMIT))
            return -TRIG_LIMIT;
        else
            return TRIG_W'(t);
    endfunction

    function automatic logic [MAG_W-1:0] mag(input logic signed [TRIG_W-1:0] v);
        logic signed [TRIG_W-1:0] a;
        a = v[TRIG_W-1] ? -v : v;
        return MAG_W'(a);
    endfunction

    function automatic logic [POS_W-1:0] apply_sign(input logic [POS_W-1:0] m, input logic neg);
        return neg ? -m : m;
    endfunction

    // Stage P1: trig values and first products
    always_comb
    begin
        slat = finish(in_data.lat.y, in_data.side.flip_lat);
        clat = finish(in_data.lat.x, in_data.side.flip_lat);
        slon = finish(in_data.lon.y, in_data.side.flip_lon);
        clon = finish(in_data.lon.x, in_data.side.flip_lon);
    end

    assign p1_ready = !p1_valid_reg || p2_ready;
    assign in_ready = p1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p1_valid_reg <= 1'b0;
        else if (p1_ready)
            p1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (p1_ready && in_valid)
        begin
            p1_mx_reg   <= PM_W'(mag(slon)) * PM_W'(mag(clat));
            p1_mz_reg   <= PM_W'(mag(clon)) * PM_W'(mag(clat));
            p1_my_reg   <= PY_W'(radius) * PY_W'(mag(slat));
            p1_nx_reg   <= slon[TRIG_W-1] ^ clat[TRIG_W-1];
            p1_nz_reg   <= clon[TRIG_W-1] ^ clat[TRIG_W-1];
            p1_ny_reg   <= slat[TRIG_W-1];
            p1_side_reg <= in_data.side;
        end
    end

    // Stage P2: radius scale, round half away from zero, sign
    always_comb
    begin
        sx = (PX_W'(radius) * PX_W'(p1_mx_reg) + (PX_W'(1) << 29)) >> 30;
        sz = (PX_W'(radius) * PX_W'(p1_mz_reg) + (PX_W'(1) << 29)) >> 30;
        sy = (p1_my_reg + (PY_W'(1) << 14)) >> 15;
        px_next = apply_sign(POS_W'(sx), p1_nx_reg);
        py_next = apply_sign(POS_W'(sy), p1_ny_reg);
        pz_next = apply_sign(POS_W'(sz), p1_nz_reg);
        if (p1_side_reg.err)
        begin
            px_next = '0;
            py_next = '0;
            pz_next = '0;
        end
    end

    assign p2_ready = !p2_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p2_valid_reg <= 1'b0;
        else if (p2_ready)
            p2_valid_reg <= p1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (p2_ready && p1_valid_reg)
        begin
            px_reg   <= px_next;
            py_reg   <= py_next;
            pz_reg   <= pz_next;
            idx_reg  <= p1_side_reg.idx;
            quad_reg <= p1_side_reg.quad;
            err_reg  <= p1_side_reg.err;
        end
    end

    assign out_valid   = p2_valid_reg;
    assign pos_x       = px_reg;
    assign pos_y       = py_reg;
    assign pos_z       = pz_reg;
    assign idx         = idx_reg;
    assign quad_valid  = quad_reg;
    assign range_error = err_reg;

endmodule
`default_nettype wire

FILE: bench/tb_uv_sphere_vertex_index_generator.sv
// Testbench of the UV-sphere vertex and index generator: random and directed grid points.
`timescale 1ns / 1ps
module tb_uv_sphere_vertex_index_generator;
    import uvs_pkg::*;

    localparam int LATENCY    = 21;
    localparam int WATCH_MAX  = 20000;
    localparam int MAX_REPORT = 10;

    typedef struct {
        logic [6:0] ring;
        logic [7:0] segment;
    } point_t;

    typedef struct {
        logic [POS_W-1:0] px, py, pz;
        logic [IDX_W-1:0] idx [6];
        logic             quad;
        logic             err;
    } vertex_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [15:0]  s_axis_tdata = '0;   // ring[6:0], segment[14:7]
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [135:0] m_axis_tdata;        // pos_x, pos_y, pos_z, six indices from bit 0 up
    logic [1:0]   m_axis_tuser;        // quad_valid[0], range_error[1]
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    // Handshake seen at the last rising edge, for the driver
    logic         s_axis_tready_q = 1'b0;

    // Predictor copy of the registers
    logic [15:0]  cur_radius = 16'd1280;
    logic [6:0]   cur_rings = 7'd15;

    point_t  pending_points[$];
    vertex_t expected_vertices[$];
    int      send_idle_pct = 36;
    int      recv_idle_pct = 76;
    int      mismatches = 0;
    int      idle_cycles = 0;

    uv_sphere_vertex_index_generator dut (.*);

    always #5 clk = ~clk;

    function automatic longint fshift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clamp_trig(longint v);
        if (v > 32767) return 32767;
        if (v < -32767) return -32767;
        return v;
    endfunction

    // Sine and cosine of a 16-bit phase by rotation
    task automatic cordic(input logic [15:0] phase, output longint s, output longint c);
        longint x, y, z, nx;
        int atan_ph [16];
        logic [15:0] p;
        bit flip;
        atan_ph = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0};
        p = phase;
        flip = 1'b0;
        x = 19898;
        y = 0;
        if (p >= 16'd16384 && p < 16'd49152)
        begin
            flip = 1'b1;
            p = p + 16'd32768;
        end
        z = (p >= 16'd32768) ? longint'(p) - 65536 : longint'(p);
        for (int k = 0; k < 16; k++)
        begin
            if (z >= 0)
            begin
                nx = x - fshift(y, k);
                y = y + fshift(x, k);
                z -= atan_ph[k];
            end
            else
            begin
                nx = x + fshift(y, k);
                y = y - fshift(x, k);
                z += atan_ph[k];
            end
            x = nx;
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        s = clamp_trig(y);
        c = clamp_trig(x);
    endtask

    function automatic longint absl(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic logic [POS_W-1:0] scaled(longint m, bit neg);
        return neg ? POS_W'(-m) : POS_W'(m);
    endfunction

    // Expected vertex and quad of one grid point
    task automatic predict_vertex(input point_t pt, output vertex_t r);
        longint v, h, st, i, j, nj, lat, lon, m, slat, clat, slon, clon, rad;
        v = cur_rings;
        if (v < 3) v = 3;
        if (v > MAX_RINGS) v = MAX_RINGS;
        h = 2 * v;
        st = h + 1;
        i = pt.ring;
        j = pt.segment;
        rad = cur_radius;
        r.px = '0; r.py = '0; r.pz = '0;
        r.quad = 1'b0; r.err = 1'b0;
        for (int k = 0; k < 6; k++) r.idx[k] = '0;
        if (i > v || j > h)
        begin
            r.err = 1'b1;
            return;
        end
        lat = ((i * 32768 + v / 2) / v + 65536 - 16384) & 16'hFFFF;
        lon = ((j * 32768 + v / 2) / v) & 16'hFFFF;
        cordic(16'(lat), slat, clat);
        cordic(16'(lon), slon, clon);
        m = (rad * absl(slon) * absl(clat) + (64'd1 << 29)) >> 30;
        r.px = scaled(m, (slon < 0) != (clat < 0));
        m = (rad * absl(slat) + (64'd1 << 14)) >> 15;
        r.py = scaled(m, slat < 0);
        m = (rad * absl(clon) * absl(clat) + (64'd1 << 29)) >> 30;
        r.pz = scaled(m, (clon < 0) != (clat < 0));
        if (i < v)
        begin
            nj = (j + 1) % st;
            r.idx[IDX_ONE_A] = IDX_W'(i * st + nj);
            r.idx[IDX_ONE_B] = IDX_W'((i + 1) * st + j);
            r.idx[IDX_ONE_C] = IDX_W'(i * st + j);
            r.idx[IDX_TWO_A] = IDX_W'((i + 1) * st + nj);
            r.idx[IDX_TWO_B] = IDX_W'((i + 1) * st + j);
            r.idx[IDX_TWO_C] = IDX_W'(i * st + nj);
            r.quad = 1'b1;
        end
    endtask

    // Driver: offer the next point, hold it until accepted; randomize receiver ready
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_axis_tvalid || s_axis_tready_q)
            begin
                if (pending_points.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    s_axis_tdata <= {1'b0, pending_points[0].segment, pending_points[0].ring};
                    s_axis_tvalid <= 1'b1;
                    pending_points.pop_front();
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
        s_axis_tready_q <= s_axis_tready;

    // Monitor: predict on accept, check results against the oldest expectation
    always @(posedge clk)
    begin
        point_t  pt;
        vertex_t e;
        bit      bad;
        bit      any;
        any = 1'b0;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            any = 1'b1;
            pt.ring = s_axis_tdata[6:0];
            pt.segment = s_axis_tdata[14:7];
            predict_vertex(pt, e);
            expected_vertices.insert(expected_vertices.size(), e);
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            any = 1'b1;
            if (expected_vertices.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORT)
                    $display("unexpected result %h", m_axis_tdata);
            end
            else
            begin
                e = expected_vertices.pop_front();
                bad = (m_axis_tdata[16:0] !== e.px) || (m_axis_tdata[33:17] !== e.py)
                    || (m_axis_tdata[50:34] !== e.pz) || (m_axis_tuser[0] !== e.quad)
                    || (m_axis_tuser[1] !== e.err);
                for (int k = 0; k < 6; k++)
                    if (m_axis_tdata[51 + 14*k +: 14] !== e.idx[k]) bad = 1'b1;
                if (bad)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORT)
                        $display("mismatch: exp x=%h y=%h z=%h idx=%p q=%b e=%b got %h user %b",
                                 e.px, e.py, e.pz, e.idx, e.quad, e.err,
                                 m_axis_tdata, m_axis_tuser);
                end
            end
        end
        idle_cycles = any ? 0 : idle_cycles + 1;
        if (idle_cycles >= WATCH_MAX)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Register write over APB, setup then access
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == 3'd0) cur_radius = val[15:0];
        else cur_rings = val[6:0];
    endtask

    task automatic wait_drained();
        while (pending_points.size() > 0 || s_axis_tvalid || expected_vertices.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    function automatic point_t any_point(int v);
        point_t p;
        if ($urandom_range(9) == 0)
        begin
            p.ring = 7'($urandom);
            p.segment = 8'($urandom);
        end
        else
        begin
            p.ring = 7'($urandom_range(v));
            p.segment = 8'($urandom_range(2 * v));
        end
        return p;
    endfunction

    task automatic push_point(input int r, input int s);
        point_t p;
        p.ring = 7'(r);
        p.segment = 8'(s);
        pending_points.insert(pending_points.size(), p);
    endtask

    initial
    begin
        int radii [6];
        int rings [6];
        int v;
        radii = '{1280, 65535, 0, 256, 40000, 1};
        rings = '{15, 64, 3, 1, 127, 20};
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        // Directed points at reset settings
        push_point(0, 0);   push_point(15, 30);  push_point(15, 0);  push_point(14, 30);
        push_point(16, 0);  push_point(0, 31);   push_point(127, 255); push_point(7, 15);
        push_point(1, 7);   push_point(8, 22);   push_point(0, 30);  push_point(7, 0);
        wait_drained();
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(3'd0, 32'(radii[ph]));
            write_reg(3'd4, 32'(rings[ph]));
            v = rings[ph] < 3 ? 3 : (rings[ph] > MAX_RINGS ? MAX_RINGS : rings[ph]);
            if (ph < 2)      begin send_idle_pct = 36; recv_idle_pct = 76; end
            else if (ph < 4) begin send_idle_pct = 76; recv_idle_pct = 36; end
            else             begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            push_point(v, 2 * v); push_point(v - 1, 2 * v); push_point(v + 1, 0);
            for (int n = 0; n < 255; n++)
                pending_points.insert(pending_points.size(), any_point(v));
            wait_drained();
        end
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
